@@ rtl/core/matrix_line_normalizer_core_macros.svh @@
// Assertion macros shared by the matrix line normaliser RTL.
`ifndef MATRIX_LINE_NORMALIZER_CORE_MACROS_SVH
`define MATRIX_LINE_NORMALIZER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define MLN_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MLN_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MLN_ASSERT_IMP(label, clk, rst, ante, cons)
`define MLN_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/mln_pkg.sv @@
// Types, constants and helper functions of the matrix line normaliser.
package mln_pkg;

  localparam int MAX_SIDE    = 64;
  localparam int MAX_TOTAL   = MAX_SIDE * MAX_SIDE;
  localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
  localparam int LINE_W      = $clog2(MAX_SIDE);
  localparam int POS_W       = $clog2(MAX_TOTAL);
  localparam int TOTAL_W     = $clog2(MAX_TOTAL + 1);
  localparam int BIN_W       = 32;
  localparam int SUM_W       = 38;
  localparam int FRAC_BITS   = 16;
  localparam int CFG_SIDE_W  = 7;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_NORM_AXIS    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NUM_COLUMNS  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NUM_ROWS     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_LINE_SUM = 2'd3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [BIN_W-1:0]      ONE_Q16       = 32'h0001_0000;
  localparam logic [BIN_W-1:0]      MIN_SUM_RESET = 32'd655;
  localparam logic [CFG_SIDE_W-1:0] SIDE_RESET    = 7'd64;

  typedef struct packed {
    logic             op;
    logic [BIN_W-1:0] bin_value;
  } in_word_t;

  typedef struct packed {
    logic [BIN_W-1:0] result_value;
    logic             scaled;
    logic             last_bin;
  } out_word_t;

  // A size register of zero counts as one; anything above the maximum is clamped.
  function automatic logic [SIDE_W-1:0] side_of(input logic [CFG_SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (int'(v) > MAX_SIDE) begin
      r = SIDE_W'(MAX_SIDE);
    end else begin
      r = SIDE_W'(v);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/mln_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module mln_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/mln_pos_div.sv @@
// Bit-serial divider that splits a bin position into line and column indices.
module mln_pos_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mln_pkg::POS_W-1:0]  dividend,
  input  logic [mln_pkg::SIDE_W-1:0] divisor,
  output logic                      done,
  output logic [mln_pkg::POS_W-1:0]  quotient,
  output logic [mln_pkg::SIDE_W-1:0] remainder
);
  import mln_pkg::*;

  localparam int CNT_W = $clog2(POS_W + 1);

  logic              running;
  logic [CNT_W-1:0]  cnt;
  logic [POS_W-1:0]  shreg;
  logic [SIDE_W-1:0] rem;
  logic [SIDE_W-1:0] dsr;
  logic [SIDE_W:0]   trial;
  logic [SIDE_W:0]   diff;
  logic              ge;

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  assign trial = {rem, shreg[POS_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(POS_W);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      dsr   <= divisor;
    end else if (running) begin
      shreg <= {shreg[POS_W-2:0], ge};
      rem   <= ge ? diff[SIDE_W-1:0] : trial[SIDE_W-1:0];
    end
  end

  assign quotient  = shreg;
  assign remainder = rem;

endmodule

@@ rtl/core/mln_ratio_div.sv @@
// Radix-2 restoring divider giving the fraction bits of bin over line sum.
module mln_ratio_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [mln_pkg::BIN_W-1:0]     dividend,
  input  logic [mln_pkg::SUM_W-1:0]     divisor,
  output logic                         done,
  output logic [mln_pkg::FRAC_BITS-1:0] quotient
);
  import mln_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic                 running;
  logic [CNT_W-1:0]     cnt;
  logic [SUM_W-1:0]     rem;
  logic [SUM_W-1:0]     dsr;
  logic [FRAC_BITS-1:0] quo;
  logic [SUM_W:0]       trial;
  logic [SUM_W:0]       diff;
  logic                 ge;

  // The dividend is below the divisor, so each step yields one fraction bit.
  assign trial = {rem, 1'b0};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(FRAC_BITS);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= SUM_W'(dividend);
      dsr <= divisor;
      quo <= '0;
    end else if (running) begin
      rem <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      quo <= {quo[FRAC_BITS-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

@@ rtl/core/matrix_line_normalizer_core.sv @@
// Top level of the matrix line normaliser: control, line sums and bin store.
//
// A command word is taken when start is high and busy is low. A load word
// (op 0) stores its bin in row-major order and adds it to its row or column
// sum; it gives no result and keeps busy high through a bit-serial position
// divide, one line-sum RAM read and one write-back. Loads past the matrix
// size, or once readout has begun, are dropped in the accepting cycle. A
// read word (op 1) returns the next bin as one result word, shown for exactly
// one cycle with result_valid; the receiver cannot hold it off. A read
// that needs no division strobes straight from the fetch, while a divided
// read also passes through the 16-step radix-2 ratio divider and its
// hand-over before its strobe. The final read (last_bin set) clears all line
// sums and starts a new matrix. Configuration writes on cfg_write take
// effect at once and should only be made while no command is in flight.
// Synchronous reset clears the line sums, the counters and the registers
// to their defaults; the bin store needs no clearing pass.
`include "matrix_line_normalizer_core_macros.svh"

module matrix_line_normalizer_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  mln_pkg::in_word_t                 cmd,
  input  logic                             cfg_write,
  input  logic [mln_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mln_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                             result_valid,
  output mln_pkg::out_word_t                result
);
  import mln_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LDIV   = 3'd1;
  localparam logic [2:0] ST_LSUM   = 3'd2;
  localparam logic [2:0] ST_RDIV   = 3'd3;
  localparam logic [2:0] ST_RFETCH = 3'd4;
  localparam logic [2:0] ST_RATIO  = 3'd5;

  logic [2:0] state;

  logic                  norm_axis;
  logic [CFG_SIDE_W-1:0] num_columns;
  logic [CFG_SIDE_W-1:0] num_rows;
  logic [BIN_W-1:0]      min_line_sum;

  logic [TOTAL_W-1:0]  load_index;
  logic [TOTAL_W-1:0]  read_index;
  logic [MAX_SIDE-1:0] sum_valid;

  logic [BIN_W-1:0]   bin_q;
  logic [POS_W-1:0]   pos_q;
  logic [TOTAL_W-1:0] total_q;
  logic               val_ok_q;
  logic [LINE_W-1:0]  line_q;
  logic               scaled_q;

  logic [SIDE_W-1:0]   cols;
  logic [SIDE_W-1:0]   rows;
  logic [2*SIDE_W-1:0] prod;
  logic [TOTAL_W-1:0]  total;
  logic [TOTAL_W-1:0]  rd_sat;
  logic                load_ok;
  logic                accept;

  logic               pdiv_start;
  logic [POS_W-1:0]   pdiv_dividend;
  logic               pdiv_done;
  logic [POS_W-1:0]   pdiv_quo;
  logic [SIDE_W-1:0]  pdiv_rem;
  logic [LINE_W-1:0]  line_now;

  logic [SUM_W-1:0]   sum_rdata;
  logic [BIN_W-1:0]   bin_rdata;
  logic [SUM_W-1:0]   sum_cur;
  logic [SUM_W:0]     sum_add;
  logic [SUM_W-1:0]   sum_new;
  logic [BIN_W-1:0]   value_cur;
  logic               scaled_cur;

  logic                 rdiv_start;
  logic                 rdiv_done;
  logic [FRAC_BITS-1:0] rdiv_quo;

  logic             fin;
  logic [BIN_W-1:0] fin_val;
  logic             fin_scaled;
  logic             last;

  assign cols    = side_of(num_columns);
  assign rows    = side_of(num_rows);
  assign prod    = {{SIDE_W{1'b0}}, cols} * {{SIDE_W{1'b0}}, rows};
  assign total   = TOTAL_W'(prod);
  // A read position beyond a shrunken matrix falls back to its final bin.
  assign rd_sat  = (read_index >= total) ? (total - TOTAL_W'(1)) : read_index;
  assign load_ok = (read_index == '0) && (load_index < total);
  assign accept  = (state == ST_IDLE) && start;
  assign busy    = (state != ST_IDLE);

  assign pdiv_start    = accept && ((cmd.op == OP_READ) || load_ok);
  assign pdiv_dividend = (cmd.op == OP_READ) ? POS_W'(rd_sat) : POS_W'(load_index);

  mln_pos_div u_pos_div (
    .clk       (clk),
    .rst       (rst),
    .start     (pdiv_start),
    .dividend  (pdiv_dividend),
    .divisor   (cols),
    .done      (pdiv_done),
    .quotient  (pdiv_quo),
    .remainder (pdiv_rem)
  );

  always_comb begin
    if (norm_axis) begin
      line_now = LINE_W'(pdiv_rem);
    end else if (pdiv_quo > POS_W'(MAX_SIDE - 1)) begin
      line_now = LINE_W'(MAX_SIDE - 1);
    end else begin
      line_now = LINE_W'(pdiv_quo);
    end
  end

  mln_ram #(.WIDTH(SUM_W), .DEPTH(MAX_SIDE)) u_sum_ram (
    .clk   (clk),
    .we    (state == ST_LSUM),
    .waddr (line_q),
    .wdata (sum_new),
    .raddr (line_now),
    .rdata (sum_rdata)
  );

  mln_ram #(.WIDTH(BIN_W), .DEPTH(MAX_TOTAL)) u_bin_ram (
    .clk   (clk),
    .we    (state == ST_LSUM),
    .waddr (pos_q),
    .wdata (bin_q),
    .raddr (pos_q),
    .rdata (bin_rdata)
  );

  // A line sum not written since the last readout reads as zero.
  assign sum_cur    = sum_valid[line_q] ? sum_rdata : '0;
  assign sum_add    = {1'b0, sum_cur} + (SUM_W + 1)'(bin_q);
  assign sum_new    = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign value_cur  = val_ok_q ? bin_rdata : '0;
  assign scaled_cur = sum_cur >= SUM_W'(min_line_sum);

  assign rdiv_start = (state == ST_RFETCH) && scaled_cur && (sum_cur != '0) &&
                      (SUM_W'(value_cur) < sum_cur);

  mln_ratio_div u_ratio_div (
    .clk      (clk),
    .rst      (rst),
    .start    (rdiv_start),
    .dividend (value_cur),
    .divisor  (sum_cur),
    .done     (rdiv_done),
    .quotient (rdiv_quo)
  );

  // A bin at or above its line sum saturates to one without dividing.
  always_comb begin
    fin        = 1'b0;
    fin_val    = '0;
    fin_scaled = scaled_q;
    case (state)
      ST_RFETCH: begin
        fin_scaled = scaled_cur;
        if (!scaled_cur) begin
          fin     = 1'b1;
          fin_val = value_cur;
        end else if (sum_cur == '0) begin
          fin     = 1'b1;
          fin_val = '0;
        end else if (SUM_W'(value_cur) >= sum_cur) begin
          fin     = 1'b1;
          fin_val = ONE_Q16;
        end
      end
      ST_RATIO: begin
        if (rdiv_done) begin
          fin     = 1'b1;
          fin_val = BIN_W'(rdiv_quo);
        end
      end
      default: begin
      end
    endcase
  end

  assign last = (TOTAL_W'(pos_q) == (total_q - TOTAL_W'(1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      norm_axis    <= 1'b0;
      num_columns  <= SIDE_RESET;
      num_rows     <= SIDE_RESET;
      min_line_sum <= MIN_SUM_RESET;
      load_index   <= '0;
      read_index   <= '0;
      sum_valid    <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= fin;

      if (cfg_write) begin
        case (cfg_index)
          REG_NORM_AXIS:    norm_axis    <= cfg_data[0];
          REG_NUM_COLUMNS:  num_columns  <= cfg_data[CFG_SIDE_W-1:0];
          REG_NUM_ROWS:     num_rows     <= cfg_data[CFG_SIDE_W-1:0];
          REG_MIN_LINE_SUM: min_line_sum <= cfg_data[BIN_W-1:0];
          default: begin
          end
        endcase
      end

      if (fin) begin
        if (last) begin
          sum_valid  <= '0;
          load_index <= '0;
          read_index <= '0;
        end else begin
          read_index <= TOTAL_W'(pos_q) + TOTAL_W'(1);
        end
      end

      case (state)
        ST_IDLE: begin
          if (pdiv_start) begin
            state <= (cmd.op == OP_READ) ? ST_RDIV : ST_LDIV;
          end
        end
        ST_LDIV: begin
          if (pdiv_done) begin
            state <= ST_LSUM;
          end
        end
        ST_LSUM: begin
          sum_valid[line_q] <= 1'b1;
          load_index        <= load_index + TOTAL_W'(1);
          state             <= ST_IDLE;
        end
        ST_RDIV: begin
          if (pdiv_done) begin
            state <= ST_RFETCH;
          end
        end
        ST_RFETCH: begin
          state <= fin ? ST_IDLE : ST_RATIO;
        end
        ST_RATIO: begin
          if (rdiv_done) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pdiv_start) begin
      bin_q    <= cmd.bin_value;
      pos_q    <= pdiv_dividend;
      total_q  <= total;
      val_ok_q <= (rd_sat < load_index);
    end
    if (pdiv_done) begin
      line_q <= line_now;
    end
    if (state == ST_RFETCH) begin
      scaled_q <= scaled_cur;
    end
    if (fin) begin
      result.result_value <= fin_val;
      result.scaled       <= fin_scaled;
      result.last_bin     <= last;
    end
  end

  `MLN_ASSERT_NXT(a_strobe_single, clk, rst, result_valid, !result_valid)
  `MLN_ASSERT_IMP(a_scaled_range, clk, rst, result_valid && result.scaled,
                  result.result_value <= ONE_Q16)
  `MLN_ASSERT_IMP(a_last_clears, clk, rst, result_valid && result.last_bin,
                  (sum_valid == '0) && (load_index == '0) && (read_index == '0))
  `MLN_ASSERT_IMP(a_load_bound, clk, rst, 1'b1, load_index <= TOTAL_W'(MAX_TOTAL))

endmodule
